FILE: rtl/core/memory_map_overlap_resolver_assert.svh
// Assertion macros for the memory map overlap resolver.
// Expects clk and rst_n in the scope of each use.
`ifndef MEMORY_MAP_OVERLAP_RESOLVER_ASSERT_SVH
`define MEMORY_MAP_OVERLAP_RESOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define MMOR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MMOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMOR_ASSERT_SAME(lbl, ante, cons, msg)
`define MMOR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mmor_pkg.sv
// Shared types and constants for the memory map overlap resolver.
// No dependencies.
`default_nettype none
package mmor_pkg;
  localparam logic [31:0] TYPE_AVAILABLE = 32'h1;
  localparam logic [31:0] TYPE_RESERVED  = 32'h2;
  localparam logic [63:0] LOW4G_LIMIT    = 64'hFFFF_FFFF;
  localparam logic        OP_LOAD        = 1'b0;
  localparam logic        OP_FINISH      = 1'b1;
  localparam logic [1:0]  ST_OK          = 2'd0;
  localparam logic [1:0]  ST_OVERFLOW    = 2'd1;
  localparam logic [1:0]  ST_EMPTY       = 2'd2;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] rtype;
  } span_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] rtype;
  } region_t;
endpackage
`default_nettype wire

FILE: rtl/core/mmor_if.sv
// Valid/ready channel interfaces for raw entries and resolved regions.
// No dependencies.
`default_nettype none
interface mmor_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] entry_base;
  logic [63:0] entry_length;
  logic [31:0] entry_type;
  modport source(output valid, opcode, entry_base, entry_length, entry_type, input ready);
  modport sink(input valid, opcode, entry_base, entry_length, entry_type, output ready);
endinterface

interface mmor_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] region_base;
  logic [63:0] region_length;
  logic [31:0] region_type;
  logic        last_region;
  logic [1:0]  status;
  modport source(output valid, region_base, region_length, region_type, last_region,
                 status, input ready);
  modport sink(input valid, region_base, region_length, region_type, last_region,
               status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mmor_region_fmt.sv
// Output formatting of one resolved region: length and 4 GB demotion/truncation.
// Depends on mmor_pkg.
`default_nettype none
module mmor_region_fmt (
  input  mmor_pkg::span_t   span,
  output mmor_pkg::region_t region
);
  logic low;
  logic avail;

  assign low   = (span.lo[63:32] == 32'd0);
  assign avail = (span.rtype == mmor_pkg::TYPE_AVAILABLE);

  always_comb begin
    region.base   = span.lo;
    region.length = span.hi - span.lo + 64'd1;
    region.rtype  = span.rtype;
    if (!low && avail) begin
      region.rtype = mmor_pkg::TYPE_RESERVED;
    end
    // cut available regions that reach 4 GB
    if (low && avail && span.hi >= mmor_pkg::LOW4G_LIMIT) begin
      region.length = mmor_pkg::LOW4G_LIMIT - span.lo;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/memory_map_overlap_resolver.sv
// Memory map overlap resolver: raw entries in, disjoint regions out in address order.
// Use: send load items (opcode 0) carrying base, length and type; each is taken
// while the block is idle. A finish item (opcode 1) starts resolution: entries
// are picked by descending type, ties in load order, by a scan of the raw entry
// memory (one read per cycle), and merged into a ping-pong region memory by a
// read-modify-write walk over the existing regions. Regions then leave one at a
// time through an output register; last_region marks the final one. Overflow of
// the entry or region table gives a single item with status 1, an empty map one
// with status 2. Stalls on the output hold the emission of regions; loads are
// accepted again once the last item sits in the output register. Reset clears
// the state, the bank, the entry and region counts and the overflow and valid
// flags; memories need none.
// Depends on mmor_pkg, mmor_if, mmor_region_fmt and the assertion header.
`default_nettype none
`include "memory_map_overlap_resolver_assert.svh"
module memory_map_overlap_resolver #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mmor_in_if.sink    in_ch,
  mmor_out_if.source out_ch
);
  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int RDP = 2 * (2 ** IW);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SCAN    = 10'b0000000010,
    S_ADD_RD  = 10'b0000000100,
    S_ADD_GAP = 10'b0000001000,
    S_ADD_CPY = 10'b0000010000,
    S_ADD_TL  = 10'b0000100000,
    S_EMIT_RD = 10'b0001000000,
    S_EMIT_LD = 10'b0010000000,
    S_STAT    = 10'b0100000000,
    S_SPARE   = 10'b1000000000
  } state_t;

  mmor_pkg::span_t raw_mem [MAX_ENTRIES];
  mmor_pkg::span_t reg_mem [RDP];
  mmor_pkg::span_t raw_rd_r, reg_rd_r;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   raw_count_r, raw_count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   rcount_r, rcount_nxt;
  logic            bank_r, bank_nxt;
  logic [CW-1:0]   scan_j_r, scan_j_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic            found_r, found_nxt;
  mmor_pkg::span_t best_r, best_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  logic            have_prev_r, have_prev_nxt;
  logic [31:0]     prev_type_r, prev_type_nxt;
  logic [IW-1:0]   prev_idx_r, prev_idx_nxt;
  logic [CW-1:0]   add_i_r, add_i_nxt;
  logic [CW-1:0]   add_n_r, add_n_nxt;
  logic [63:0]     cur_r, cur_nxt;
  logic            done_r, done_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [CW-1:0]   emit_i_r, emit_i_nxt;
  logic            out_valid_r, out_valid_nxt;
  mmor_pkg::region_t out_reg_r, out_reg_nxt;
  logic            out_last_r, out_last_nxt;
  logic [1:0]      out_stat_r, out_stat_nxt;

  logic            raw_we, raw_re;
  logic [IW-1:0]   raw_raddr;
  mmor_pkg::span_t raw_wdata;
  logic            reg_we, reg_re;
  logic [IW:0]     reg_waddr, reg_raddr;
  mmor_pkg::span_t reg_wdata;

  logic            in_acc, slot_free;
  logic [63:0]     load_hi, gap_end;
  logic            gap, elig, better;
  mmor_pkg::region_t fmt_region;

  mmor_region_fmt u_fmt (
    .span   (reg_rd_r),
    .region (fmt_region)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign slot_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.region_base   = out_reg_r.base;
  assign out_ch.region_length = out_reg_r.length;
  assign out_ch.region_type   = out_reg_r.rtype;
  assign out_ch.last_region   = out_last_r;
  assign out_ch.status        = out_stat_r;

  // clip at the top of the address space
  assign load_hi = (in_ch.entry_length - 64'd1 > ~in_ch.entry_base) ? '1 :
                   in_ch.entry_base + (in_ch.entry_length - 64'd1);

  assign elig   = !have_prev_r || (raw_rd_r.rtype < prev_type_r) ||
                  (raw_rd_r.rtype == prev_type_r && cmp_idx_r > prev_idx_r);
  assign better = !found_r || (raw_rd_r.rtype > best_r.rtype);

  assign gap     = !done_r && (reg_rd_r.lo > cur_r) && (cur_r <= best_r.hi);
  assign gap_end = (reg_rd_r.lo - 64'd1 > best_r.hi) ? best_r.hi : reg_rd_r.lo - 64'd1;

  always_comb begin
    state_nxt     = state_r;
    raw_count_nxt = raw_count_r;
    ovf_nxt       = ovf_r;
    rcount_nxt    = rcount_r;
    bank_nxt      = bank_r;
    scan_j_nxt    = scan_j_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    have_prev_nxt = have_prev_r;
    prev_type_nxt = prev_type_r;
    prev_idx_nxt  = prev_idx_r;
    add_i_nxt     = add_i_r;
    add_n_nxt     = add_n_r;
    cur_nxt       = cur_r;
    done_nxt      = done_r;
    stat_nxt      = stat_r;
    emit_i_nxt    = emit_i_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_reg_nxt   = out_reg_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    raw_we        = 1'b0;
    raw_wdata     = '{lo: in_ch.entry_base, hi: load_hi, rtype: in_ch.entry_type};
    raw_re        = 1'b0;
    raw_raddr     = scan_j_r[IW-1:0];
    reg_we        = 1'b0;
    reg_waddr     = {!bank_r, add_n_r[IW-1:0]};
    reg_wdata     = reg_rd_r;
    reg_re        = 1'b0;
    reg_raddr     = {bank_r, add_i_r[IW-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.opcode == mmor_pkg::OP_LOAD) begin
          if (in_ch.entry_length != 64'd0) begin
            if (raw_count_r == MAXC) begin
              ovf_nxt = 1'b1;
            end else begin
              raw_we        = 1'b1;
              raw_count_nxt = raw_count_r + CW'(1);
            end
          end
        end else if (in_acc) begin
          if (ovf_r) begin
            stat_nxt  = mmor_pkg::ST_OVERFLOW;
            state_nxt = S_STAT;
          end else begin
            rcount_nxt    = '0;
            have_prev_nxt = 1'b0;
            scan_j_nxt    = '0;
            found_nxt     = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && elig && better) begin
          found_nxt    = 1'b1;
          best_nxt     = raw_rd_r;
          best_idx_nxt = cmp_idx_r;
        end
        if (scan_j_r < raw_count_r) begin
          raw_re      = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_j_r[IW-1:0];
          scan_j_nxt  = scan_j_r + CW'(1);
        end else if (!cmp_vld_r) begin
          if (found_r) begin
            have_prev_nxt = 1'b1;
            prev_type_nxt = best_r.rtype;
            prev_idx_nxt  = best_idx_r;
            add_i_nxt     = '0;
            add_n_nxt     = '0;
            cur_nxt       = best_r.lo;
            done_nxt      = 1'b0;
            state_nxt     = S_ADD_RD;
          end else if (rcount_r == '0) begin
            stat_nxt  = mmor_pkg::ST_EMPTY;
            state_nxt = S_STAT;
          end else begin
            emit_i_nxt = '0;
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      S_ADD_RD: begin
        if (add_i_r < rcount_r) begin
          reg_re    = 1'b1;
          state_nxt = S_ADD_GAP;
        end else begin
          state_nxt = S_ADD_TL;
        end
      end
      S_ADD_GAP: begin
        state_nxt = S_ADD_CPY;
        if (gap) begin
          if (add_n_r == MAXC) begin
            stat_nxt  = mmor_pkg::ST_OVERFLOW;
            state_nxt = S_STAT;
          end else begin
            reg_we    = 1'b1;
            reg_wdata = '{lo: cur_r, hi: gap_end, rtype: best_r.rtype};
            add_n_nxt = add_n_r + CW'(1);
            if (gap_end == best_r.hi) begin
              done_nxt = 1'b1;
            end else begin
              cur_nxt = gap_end + 64'd1;
            end
          end
        end
      end
      S_ADD_CPY: begin
        if (add_n_r == MAXC) begin
          stat_nxt  = mmor_pkg::ST_OVERFLOW;
          state_nxt = S_STAT;
        end else begin
          reg_we    = 1'b1;
          add_n_nxt = add_n_r + CW'(1);
          add_i_nxt = add_i_r + CW'(1);
          if (!done_r && reg_rd_r.hi >= cur_r) begin
            if (reg_rd_r.hi >= best_r.hi) begin
              done_nxt = 1'b1;
            end else begin
              cur_nxt = reg_rd_r.hi + 64'd1;
            end
          end
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_TL: begin
        if (!done_r && cur_r <= best_r.hi && add_n_r == MAXC) begin
          stat_nxt  = mmor_pkg::ST_OVERFLOW;
          state_nxt = S_STAT;
        end else begin
          if (!done_r && cur_r <= best_r.hi) begin
            reg_we     = 1'b1;
            reg_wdata  = '{lo: cur_r, hi: best_r.hi, rtype: best_r.rtype};
            rcount_nxt = add_n_r + CW'(1);
          end else begin
            rcount_nxt = add_n_r;
          end
          // swap banks, rescan for the next entry
          bank_nxt   = !bank_r;
          scan_j_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_EMIT_RD: begin
        reg_re    = 1'b1;
        reg_raddr = {bank_r, emit_i_r[IW-1:0]};
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_reg_nxt   = fmt_region;
          out_stat_nxt  = mmor_pkg::ST_OK;
          out_last_nxt  = (emit_i_r + CW'(1) == rcount_r);
          emit_i_nxt    = emit_i_r + CW'(1);
          if (emit_i_r + CW'(1) == rcount_r) begin
            raw_count_nxt = '0;
            rcount_nxt    = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_reg_nxt   = '0;
          out_stat_nxt  = stat_r;
          out_last_nxt  = 1'b1;
          raw_count_nxt = '0;
          rcount_nxt    = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[raw_count_r[IW-1:0]] <= raw_wdata;
    end
    if (raw_re) begin
      raw_rd_r <= raw_mem[raw_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
    if (reg_re) begin
      reg_rd_r <= reg_mem[reg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      raw_count_r <= '0;
      ovf_r       <= 1'b0;
      rcount_r    <= '0;
      bank_r      <= 1'b0;
      cmp_vld_r   <= 1'b0;
      add_n_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      raw_count_r <= raw_count_nxt;
      ovf_r       <= ovf_nxt;
      rcount_r    <= rcount_nxt;
      bank_r      <= bank_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      add_n_r     <= add_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_j_r    <= scan_j_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    have_prev_r <= have_prev_nxt;
    prev_type_r <= prev_type_nxt;
    prev_idx_r  <= prev_idx_nxt;
    add_i_r     <= add_i_nxt;
    cur_r       <= cur_nxt;
    done_r      <= done_nxt;
    stat_r      <= stat_nxt;
    emit_i_r    <= emit_i_nxt;
    out_reg_r   <= out_reg_nxt;
    out_last_r  <= out_last_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  `MMOR_ASSERT_SAME(a_raw_cap, 1'b1, raw_count_r <= MAXC, "raw count beyond capacity")
  `MMOR_ASSERT_SAME(a_reg_cap, 1'b1, rcount_r <= MAXC && add_n_r <= MAXC || state_r == S_IDLE,
    "region count beyond capacity")
  `MMOR_ASSERT_NEXT(a_stat_last, state_r == S_STAT && slot_free,
    out_valid_r && out_last_r && state_r == S_IDLE, "status item not marked last")
endmodule
`default_nettype wire
